// ----- rtl/core/bcdp_pkg.sv -----
// shared types and constants for the bezier curve disc plotter
package bcdp_pkg;

    localparam int DEF_MAX_POINTS = 8;
    localparam int DEF_MAX_RADIUS = 4;

    localparam int PTR_W   = 4;
    localparam int NP_W    = 4;
    localparam int RAD_W   = 3;
    localparam int DIM_W   = 13;
    localparam int COORD_W = 16;
    localparam int T_W     = 10;
    localparam int IDX_W   = 3;
    localparam int PIX_W   = 12;
    localparam int XW      = DIM_W + 1;

    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;
    localparam int IN_DW   = 48;
    localparam int OUT_DW  = 24;

    typedef enum logic [1:0] {
        REG_NUM_POINTS   = 2'd0,
        REG_BRUSH_RADIUS = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } t_reg_idx;

    localparam logic [NP_W-1:0]  RST_NUM_POINTS   = 4'd4;
    localparam logic [RAD_W-1:0] RST_BRUSH_RADIUS = 3'd1;
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic [NP_W-1:0]  num_points;
        logic [RAD_W-1:0] brush_radius;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } t_cfg;

    typedef struct packed {
        logic             store_pt;
        logic             load_t;
        logic [PTR_W-1:0] rd_addr;
        logic             wr_work;
        logic [PTR_W-1:0] wr_addr;
        logic             lerp;
        logic             drop;
        logic [PTR_W-1:0] ins_pos;
        logic             prep;
        logic             scan;
        logic             flush;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_end;
        logic pend_v;
    } t_dp_sts;

endpackage

// ----- rtl/core/bcdp_regs.sv -----
// apb configuration registers of the bezier curve disc plotter
module bcdp_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcdp_pkg::APB_AW-1:0]   paddr,
    input  logic [bcdp_pkg::APB_DW-1:0]   pwdata,
    output logic [bcdp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output bcdp_pkg::t_cfg                o_cfg
);
    import bcdp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_points   <= RST_NUM_POINTS;
            r_cfg.brush_radius <= RST_BRUSH_RADIUS;
            r_cfg.image_width  <= RST_IMAGE_WIDTH;
            r_cfg.image_height <= RST_IMAGE_HEIGHT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NUM_POINTS:   r_cfg.num_points   <= pwdata[NP_W-1:0];
                REG_BRUSH_RADIUS: r_cfg.brush_radius <= pwdata[RAD_W-1:0];
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NUM_POINTS:   prdata = APB_DW'(r_cfg.num_points);
            REG_BRUSH_RADIUS: prdata = APB_DW'(r_cfg.brush_radius);
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_cfg.image_height);
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- rtl/core/bcdp_ctrl.sv -----
// controller state machine sequencing copy, interpolation, pixel scan and final flush
module bcdp_ctrl #(
    parameter int MAX_POINTS = bcdp_pkg::DEF_MAX_POINTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_valid,
    input  logic                        i_op,
    input  logic [bcdp_pkg::NP_W-1:0]   i_num_points,
    input  bcdp_pkg::t_dp_sts           i_sts,
    output logic                        o_s_ready,
    output bcdp_pkg::t_dp_cmd           o_cmd
);
    import bcdp_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_LERP,
        ST_DROP,
        ST_PREP,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_m;
    logic [CNT_W-1:0] n;
    logic             accept;

    always_comb begin
        if (i_num_points == '0) begin
            n = CNT_W'(1);
        end else if (int'(i_num_points) > MAX_POINTS) begin
            n = CNT_W'(MAX_POINTS);
        end else begin
            n = CNT_W'(i_num_points);
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign accept    = i_s_valid && o_s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_m     <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && i_op == OP_EVAL) begin
                        r_cnt   <= '0;
                        r_state <= ST_COPY;
                    end
                end
                ST_COPY: begin
                    if (r_cnt == n) begin
                        if (n == CNT_W'(1)) begin
                            r_state <= ST_PREP;
                        end else begin
                            r_m     <= n;
                            r_cnt   <= CNT_W'(1);
                            r_state <= ST_LERP;
                        end
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_LERP: begin
                    if (r_cnt == r_m - CNT_W'(1)) begin
                        r_state <= ST_DROP;
                    end else begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_DROP: begin
                    r_m <= r_m - CNT_W'(1);
                    if (r_m == CNT_W'(2)) begin
                        r_state <= ST_PREP;
                    end else begin
                        r_cnt   <= CNT_W'(1);
                        r_state <= ST_LERP;
                    end
                end
                ST_PREP: r_state <= ST_SCAN;
                ST_SCAN: begin
                    if (i_sts.scan_end) begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    if (!i_sts.pend_v) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.store_pt = accept && (i_op == OP_LOAD);
        o_cmd.load_t   = accept && (i_op == OP_EVAL);
        o_cmd.rd_addr  = PTR_W'(r_cnt);
        o_cmd.wr_work  = (r_state == ST_COPY) && (r_cnt != '0);
        o_cmd.wr_addr  = PTR_W'(r_cnt - CNT_W'(1));
        o_cmd.lerp     = (r_state == ST_LERP);
        o_cmd.drop     = (r_state == ST_DROP);
        o_cmd.ins_pos  = PTR_W'(r_m - CNT_W'(1));
        o_cmd.prep     = (r_state == ST_PREP);
        o_cmd.scan     = (r_state == ST_SCAN);
        o_cmd.flush    = (r_state == ST_FLUSH);
    end

    lerp_pass_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LERP) |-> (r_m >= CNT_W'(2)) && (r_cnt != '0) && (r_cnt < r_m))
        else $error("interpolation step outside its pass");

    scan_after_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREP) |=> (r_state == ST_SCAN))
        else $error("setup not followed by scan");

    copy_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COPY) |-> (r_cnt <= n))
        else $error("copy counter overran point count");

endmodule

// ----- rtl/core/bcdp_dpath.sv -----
// datapath: point store, de casteljau work registers, disc scan and output stage
module bcdp_dpath #(
    parameter int MAX_POINTS = bcdp_pkg::DEF_MAX_POINTS,
    parameter int MAX_RADIUS = bcdp_pkg::DEF_MAX_RADIUS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bcdp_pkg::t_dp_cmd             i_cmd,
    input  bcdp_pkg::t_cfg                i_cfg,
    input  logic [bcdp_pkg::IDX_W-1:0]    i_point_index,
    input  logic [bcdp_pkg::COORD_W-1:0]  i_point_x,
    input  logic [bcdp_pkg::COORD_W-1:0]  i_point_y,
    input  logic [bcdp_pkg::T_W-1:0]      i_t_value,
    input  logic                          i_m_ready,
    output bcdp_pkg::t_dp_sts             o_sts,
    output logic                          o_m_valid,
    output logic [bcdp_pkg::PIX_W-1:0]    o_pixel_x,
    output logic [bcdp_pkg::PIX_W-1:0]    o_pixel_y,
    output logic                          o_last
);
    import bcdp_pkg::*;

    localparam int PW    = $clog2(MAX_POINTS);
    localparam int PL    = COORD_W + T_W + 2;
    localparam int R16_W = $clog2(16 * MAX_RADIUS + 1);
    localparam int DW    = $clog2(16 * MAX_RADIUS + 16) + 1;
    localparam int SQ_W  = 2 * DW + 1;
    localparam int LW    = XW + 4;

    logic [2*COORD_W-1:0] r_store [MAX_POINTS];
    logic [2*COORD_W-1:0] r_rdata;
    logic [COORD_W-1:0]   r_wx [MAX_POINTS];
    logic [COORD_W-1:0]   r_wy [MAX_POINTS];
    logic [T_W-1:0]       r_t;

    // point store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_pt && int'(i_point_index) < MAX_POINTS) begin
            r_store[PW'(i_point_index)] <= {i_point_y, i_point_x};
        end
        r_rdata <= r_store[i_cmd.rd_addr[PW-1:0]];
        if (i_cmd.load_t) begin
            r_t <= i_t_value;
        end
    end

    // one interpolation of the two head entries
    logic signed [COORD_W:0] dfx, dfy;
    logic signed [PL-1:0]    prx, pry, adx, ady;
    logic [PL-1:0]           rndx, rndy;
    logic [COORD_W-1:0]      new_x, new_y;

    always_comb begin
        dfx  = $signed({r_wx[1][COORD_W-1], r_wx[1]}) - $signed({r_wx[0][COORD_W-1], r_wx[0]});
        dfy  = $signed({r_wy[1][COORD_W-1], r_wy[1]}) - $signed({r_wy[0][COORD_W-1], r_wy[0]});
        prx  = dfx * $signed({1'b0, r_t});
        pry  = dfy * $signed({1'b0, r_t});
        rndx = prx[PL-1] ? PL'((1 << T_W) - 1) : '0;
        rndy = pry[PL-1] ? PL'((1 << T_W) - 1) : '0;
        adx  = prx + $signed(rndx);
        ady  = pry + $signed(rndy);
        new_x = r_wx[0] + adx[T_W+COORD_W-1:T_W];
        new_y = r_wy[0] + ady[T_W+COORD_W-1:T_W];
    end

    // work registers: filled from the store, then shifted toward the head
    for (genvar j = 0; j < MAX_POINTS; j++) begin : g_work
        localparam int JN = (j < MAX_POINTS - 1) ? j + 1 : j;
        always_ff @(posedge i_clk) begin
            if (i_cmd.wr_work && i_cmd.wr_addr[PW-1:0] == PW'(j)) begin
                r_wx[j] <= r_rdata[COORD_W-1:0];
                r_wy[j] <= r_rdata[2*COORD_W-1:COORD_W];
            end else if (i_cmd.lerp && i_cmd.ins_pos[PW-1:0] == PW'(j)) begin
                r_wx[j] <= new_x;
                r_wy[j] <= new_y;
            end else if (i_cmd.lerp || i_cmd.drop) begin
                r_wx[j] <= r_wx[JN];
                r_wy[j] <= r_wy[JN];
            end
        end
    end

    // scan window setup
    logic [RAD_W-1:0]     rad;
    logic [R16_W-1:0]     r16;
    logic signed [LW-1:0] vx_e, vy_e, r16_e, sx, sy, sx_adj, sy_adj;
    logic [SQ_W-1:0]      r2;

    always_comb begin
        rad    = (int'(i_cfg.brush_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS)
                                                         : i_cfg.brush_radius;
        r16    = R16_W'({rad, 4'b0000});
        r2     = SQ_W'(r16) * SQ_W'(r16);
        vx_e   = {{(LW-COORD_W){r_wx[0][COORD_W-1]}}, r_wx[0]};
        vy_e   = {{(LW-COORD_W){r_wy[0][COORD_W-1]}}, r_wy[0]};
        r16_e  = {{(LW-R16_W){1'b0}}, r16};
        sx     = vx_e - r16_e;
        sy     = vy_e - r16_e;
        sx_adj = sx + (sx[LW-1] ? LW'(15) : LW'(0));
        sy_adj = sy + (sy[LW-1] ? LW'(15) : LW'(0));
    end

    logic signed [XW-1:0] r_x, r_y, r_x0;
    logic signed [LW-1:0] r_limx, r_limy;

    // candidate pixel test
    logic signed [LW-1:0]   x16, y16, dxf, dyf;
    logic signed [DW-1:0]   dxn, dyn;
    logic signed [2*DW-1:0] dxsq, dysq;
    logic [SQ_W-1:0]        dsum;
    logic row_ok, col_ok, col_next_ok, in_img, pix_ok, emit, out_free, stall, adv;

    logic             r_pend_v, r_out_v, r_out_last;
    logic [PIX_W-1:0] r_pend_x, r_pend_y, r_out_x, r_out_y;

    always_comb begin
        x16         = {r_x, 4'b0000};
        y16         = {r_y, 4'b0000};
        row_ok      = y16 < r_limy;
        col_ok      = x16 < r_limx;
        col_next_ok = x16 < (r_limx - LW'(16));
        in_img      = !r_x[XW-1] && !r_y[XW-1]
                      && ($unsigned(r_x) < {1'b0, i_cfg.image_width})
                      && ($unsigned(r_y) < {1'b0, i_cfg.image_height});
        dxf         = x16 - vx_e;
        dyf         = y16 - vy_e;
        dxn         = dxf[DW-1:0];
        dyn         = dyf[DW-1:0];
        dxsq        = dxn * dxn;
        dysq        = dyn * dyn;
        dsum        = SQ_W'($unsigned(dxsq)) + SQ_W'($unsigned(dysq));
        pix_ok      = dsum < r2;
        emit        = i_cmd.scan && row_ok && col_ok && in_img && pix_ok;
        out_free    = !r_out_v || i_m_ready;
        stall       = emit && r_pend_v && !out_free;
        adv         = i_cmd.scan && row_ok && !stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_x0   <= sx_adj[LW-1:4];
            r_x    <= sx_adj[LW-1:4];
            r_y    <= sy_adj[LW-1:4];
            r_limx <= vx_e + r16_e;
            r_limy <= vy_e + r16_e;
        end else if (adv) begin
            if (col_ok && col_next_ok) begin
                r_x <= r_x + XW'(1);
            end else begin
                r_x <= r_x0;
                r_y <= r_y + XW'(1);
            end
        end
    end

    // one pixel held back so the final one can carry last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (adv && emit) begin
                if (r_pend_v) begin
                    r_out_v    <= 1'b1;
                    r_out_x    <= r_pend_x;
                    r_out_y    <= r_pend_y;
                    r_out_last <= 1'b0;
                end else if (i_m_ready) begin
                    r_out_v <= 1'b0;
                end
                r_pend_v <= 1'b1;
                r_pend_x <= r_x[PIX_W-1:0];
                r_pend_y <= r_y[PIX_W-1:0];
            end else if (i_cmd.flush && r_pend_v && out_free) begin
                r_out_v    <= 1'b1;
                r_out_x    <= r_pend_x;
                r_out_y    <= r_pend_y;
                r_out_last <= 1'b1;
                r_pend_v   <= 1'b0;
            end else if (i_m_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_sts.scan_end = i_cmd.scan && !row_ok;
    assign o_sts.pend_v   = r_pend_v;
    assign o_m_valid      = r_out_v;
    assign o_pixel_x      = r_out_x;
    assign o_pixel_y      = r_out_y;
    assign o_last         = r_out_last;

    scan_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan && stall) |=> $stable(r_x) && $stable(r_y) && r_pend_v)
        else $error("scan moved while the output stage was full");

    flush_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.flush && r_pend_v && out_free) |=> r_out_v && r_out_last && !r_pend_v)
        else $error("final pixel not marked last");

    inner_pixel_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && emit && r_pend_v) |=> r_out_v && !r_out_last && r_pend_v)
        else $error("held pixel lost or marked last early");

endmodule

// ----- rtl/core/bezier_curve_disc_plotter_core.sv -----
// top level of the bezier curve disc plotter
//
// input stream: tuser carries op (0 load point, 1 evaluate). a load writes
// point_x/point_y into slot point_index and the block stays idle. an evaluate
// copies num_points stored points, clamped to 1..MAX_POINTS, into work
// registers, runs de casteljau interpolation one step per cycle with a drop
// step after each level, takes a setup step, then scans the square around
// the curve point one candidate pixel per cycle while no stalled receiver
// holds it, at most (2r+1)^2 candidates, then ends the scan and hands off the
// final pixel, if any, before it returns to idle; a stalled receiver that
// blocks the scan lengthens the evaluate.
// the next item is accepted once the previous evaluate has moved its final
// pixel, if any, into the output register.
// output stream: one transfer per pixel inside the disc and the image,
// tlast on the final pixel of an evaluate; an evaluate with no pixel in the
// image gives no transfer. a stalled receiver holds the scan, nothing is lost.
// configuration through the apb port, written only while the block is idle;
// the user must keep to this, it is not checked. reset restores the register
// defaults and empties the pipeline; the point store keeps no reset value.
module bezier_curve_disc_plotter_core #(
    parameter int MAX_POINTS = bcdp_pkg::DEF_MAX_POINTS,
    parameter int MAX_RADIUS = bcdp_pkg::DEF_MAX_RADIUS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bcdp_pkg::APB_AW-1:0]   paddr,
    input  logic [bcdp_pkg::APB_DW-1:0]   pwdata,
    output logic [bcdp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // point_index, point_x, point_y, t_value, zero fill
    input  logic [bcdp_pkg::IN_DW-1:0]    s_axis_tdata,
    // op
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // pixel_x, pixel_y
    output logic [bcdp_pkg::OUT_DW-1:0]   m_axis_tdata,
    output logic                          m_axis_tlast
);
    import bcdp_pkg::*;

    t_cfg             cfg;
    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [PIX_W-1:0] pixel_x, pixel_y;

    bcdp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bcdp_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .i_op         (s_axis_tuser),
        .i_num_points (cfg.num_points),
        .i_sts        (sts),
        .o_s_ready    (s_axis_tready),
        .o_cmd        (cmd)
    );

    bcdp_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg         (cfg),
        .i_point_index (s_axis_tdata[IDX_W-1:0]),
        .i_point_x     (s_axis_tdata[IDX_W+COORD_W-1:IDX_W]),
        .i_point_y     (s_axis_tdata[IDX_W+2*COORD_W-1:IDX_W+COORD_W]),
        .i_t_value     (s_axis_tdata[IDX_W+2*COORD_W+T_W-1:IDX_W+2*COORD_W]),
        .i_m_ready     (m_axis_tready),
        .o_sts         (sts),
        .o_m_valid     (m_axis_tvalid),
        .o_pixel_x     (pixel_x),
        .o_pixel_y     (pixel_y),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {pixel_y, pixel_x};

endmodule

// ----- tb/testbench.sv -----
// self-checking testbench for the bezier curve disc plotter core
module testbench;
    import bcdp_pkg::*;

    typedef struct {
        logic [PIX_W-1:0] col;
        logic [PIX_W-1:0] row;
        logic             last;
    } t_pixel;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    // point_index, point_x, point_y, t_value, zero fill
    logic [IN_DW-1:0]    s_axis_tdata;
    // op
    logic                s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // pixel_x, pixel_y
    logic [OUT_DW-1:0]   m_axis_tdata;
    logic                m_axis_tlast;

    // mirror of the block state
    logic signed [COORD_W-1:0] pt_x [DEF_MAX_POINTS];
    logic signed [COORD_W-1:0] pt_y [DEF_MAX_POINTS];
    logic [NP_W-1:0]           cfg_points;
    logic [RAD_W-1:0]          cfg_radius;
    logic [DIM_W-1:0]          cfg_width;
    logic [DIM_W-1:0]          cfg_height;

    t_pixel      pending_pixels [$];
    t_pixel      want_px;
    int unsigned err_cnt = 0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;

    bezier_curve_disc_plotter_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    task automatic note_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("error: %s", msg);
    endtask

    function automatic int lerp_t(input int a, input int b, input int t);
        return a + ((b - a) * t) / 1024;
    endfunction

    // de casteljau point, then every disc pixel inside the image
    function automatic void trace_disc(input logic [T_W-1:0] tv);
        int     wx [DEF_MAX_POINTS];
        int     wy [DEF_MAX_POINTS];
        int     n, rad, r16, vx, vy, x0, y0, x, y, dx, dy, i, k, t, wlim, hlim;
        t_pixel hits [$];
        t_pixel p;
        t = int'(tv);
        n = int'(cfg_points);
        if (n < 1) n = 1;
        if (n > DEF_MAX_POINTS) n = DEF_MAX_POINTS;
        for (i = 0; i < n; i++) begin
            wx[i] = int'(pt_x[i]);
            wy[i] = int'(pt_y[i]);
        end
        for (k = 1; k < n; k++) begin
            for (i = 0; i + k < n; i++) begin
                wx[i] = lerp_t(wx[i], wx[i+1], t);
                wy[i] = lerp_t(wy[i], wy[i+1], t);
            end
        end
        vx = wx[0];
        vy = wy[0];
        rad = int'(cfg_radius);
        if (rad > DEF_MAX_RADIUS) rad = DEF_MAX_RADIUS;
        r16 = rad * 16;
        wlim = int'(cfg_width);
        hlim = int'(cfg_height);
        x0 = (vx - r16) / 16;
        y0 = (vy - r16) / 16;
        for (y = y0; y * 16 < vy + r16; y++) begin
            for (x = x0; x * 16 < vx + r16; x++) begin
                dx = x * 16 - vx;
                dy = y * 16 - vy;
                if (x >= 0 && y >= 0 && x < wlim && y < hlim &&
                    dx * dx + dy * dy < r16 * r16 && hits.size() < 64) begin
                    p.col  = x[PIX_W-1:0];
                    p.row  = y[PIX_W-1:0];
                    p.last = 1'b0;
                    hits.push_back(p);
                end
            end
        end
        for (i = 0; i < hits.size(); i++) begin
            p = hits[i];
            p.last = (i == hits.size() - 1);
            pending_pixels.push_back(p);
        end
    endfunction

    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                             input logic [T_W-1:0] tv);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, tv, py, px, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (op == OP_LOAD) begin
            pt_x[idx] = px;
            pt_y[idx] = py;
        end else begin
            trace_disc(tv);
        end
        @(negedge i_clk);
    endtask

    task automatic load_pt(input logic [IDX_W-1:0] idx, input logic [COORD_W-1:0] px,
                           input logic [COORD_W-1:0] py);
        send_item(OP_LOAD, idx, px, py, T_W'($urandom));
    endtask

    task automatic eval_at(input logic [T_W-1:0] tv);
        send_item(OP_EVAL, IDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), tv);
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // evaluates with no pixel may still be busy after the last transfer
    task automatic settle();
        hold_until_drained();
        repeat (300) @(negedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx r, input logic [APB_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (r)
            REG_NUM_POINTS:   cfg_points = v[NP_W-1:0];
            REG_BRUSH_RADIUS: cfg_radius = v[RAD_W-1:0];
            REG_IMAGE_WIDTH:  cfg_width  = v[DIM_W-1:0];
            REG_IMAGE_HEIGHT: cfg_height = v[DIM_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input int n, input int r, input int w, input int h);
        apb_write(REG_NUM_POINTS, n);
        apb_write(REG_BRUSH_RADIUS, r);
        apb_write(REG_IMAGE_WIDTH, w);
        apb_write(REG_IMAGE_HEIGHT, h);
    endtask

    function automatic int pick_dim();
        case ($urandom_range(0, 5))
            0:       return 1;
            1:       return 4096;
            2:       return $urandom_range(1, 4096);
            default: return $urandom_range(8, 700);
        endcase
    endfunction

    // mostly near the visible area, sometimes anywhere
    function automatic logic [COORD_W-1:0] rand_coord(input int dim);
        int hi, v;
        if ($urandom_range(0, 4) == 0) return COORD_W'($urandom);
        hi = dim * 16 + 48;
        if (hi > 32767) hi = 32767;
        v = int'($urandom_range(0, hi + 48)) - 48;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [T_W-1:0] rand_t();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return T_W'($urandom_range(0, 1023));
        endcase
    endfunction

    task automatic test_default_config();
        int i;
        for (i = 0; i < DEF_MAX_POINTS; i++)
            load_pt(IDX_W'(i), COORD_W'((80 + 10 * i) * 16 + i),
                    COORD_W'((120 - 5 * i) * 16 + 3 * i));
        eval_at(T_W'(0));
        eval_at(T_W'(1023));
        eval_at(T_W'(512));
    endtask

    task automatic test_field_extremes();
        settle();
        set_config(1, 4, 4096, 4096);
        load_pt(IDX_W'(0), 16'h7fff, 16'h7fff);
        eval_at(T_W'(0));
        load_pt(IDX_W'(0), 16'h8000, 16'h8000);
        eval_at(T_W'(1023));
        load_pt(IDX_W'(0), 16'h0000, 16'h0000);
        eval_at(T_W'(0));
        settle();
        // radius clamp, one pixel image
        set_config(8, 7, 1, 1);
        eval_at(T_W'(0));
        eval_at(T_W'(1023));
        settle();
        set_config(0, 0, 640, 480);
        eval_at(T_W'(300));
        settle();
        set_config(15, 2, 640, 480);
        load_pt(IDX_W'(7), 16'h7fff, 16'h8000);
        load_pt(IDX_W'(3), -16'sd20, 16'sd5);
        eval_at(T_W'(1023));
        eval_at(T_W'(511));
        eval_at(T_W'(0));
    endtask

    task automatic test_random_curves();
        int phase, j, n, r, w, h;
        for (phase = 0; phase < 6; phase++) begin
            settle();
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            w = pick_dim();
            h = pick_dim();
            set_config(n, r, w, h);
            tx_quiet = (phase % 3 == 2);
            for (j = 0; j < 22; j++) begin
                if ($urandom_range(0, 15) == 0) hold_until_drained();
                if ($urandom_range(0, 99) < 35)
                    load_pt(IDX_W'($urandom_range(0, 7)), rand_coord(w), rand_coord(h));
                else
                    eval_at(rand_t());
            end
        end
        tx_quiet = 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                note_error($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                    m_axis_tdata[PIX_W-1:0], m_axis_tdata[2*PIX_W-1:PIX_W], m_axis_tlast));
            end else begin
                want_px = pending_pixels.pop_front();
                if (m_axis_tdata[PIX_W-1:0] !== want_px.col ||
                    m_axis_tdata[2*PIX_W-1:PIX_W] !== want_px.row ||
                    m_axis_tlast !== want_px.last)
                    note_error($sformatf("pixel exp x=%0d y=%0d last=%0b got x=%0d y=%0d last=%0b",
                        want_px.col, want_px.row, want_px.last, m_axis_tdata[PIX_W-1:0],
                        m_axis_tdata[2*PIX_W-1:PIX_W], m_axis_tlast));
            end
        end
    end

    // receiver with random stalls
    initial begin
        int gap;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            gap = rx_quiet ? 0 : $urandom_range(0, 9);
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
            @(negedge i_clk);
            if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        end
    end

    initial begin
        #2000000;
        $display("FAIL bezier_curve_disc_plotter_core");
        $finish;
    end

    initial begin
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_LOAD;
        cfg_points    = RST_NUM_POINTS;
        cfg_radius    = RST_BRUSH_RADIUS;
        cfg_width     = RST_IMAGE_WIDTH;
        cfg_height    = RST_IMAGE_HEIGHT;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_config();
        test_field_extremes();
        test_random_curves();

        hold_until_drained();
        repeat (300) @(posedge i_clk);
        if (pending_pixels.size() != 0)
            note_error($sformatf("%0d pixels never arrived", pending_pixels.size()));
        if (err_cnt == 0) begin
            $display("PASS bezier_curve_disc_plotter_core");
        end else begin
            $display("FAIL bezier_curve_disc_plotter_core");
        end
        $finish;
    end

endmodule
